/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the classifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define SNLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define SNLC_ASSERT_IMPL(label, ante, cons, msg) \
  `SNLC_ASSERT(label, (ante) |-> (cons), msg)

`endif

/* rtl/snlc_pkg.sv */
// ----------------------------------------------------------------------------
// snlc_pkg
// Types and character constants for the SQL numeric literal classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package snlc_pkg;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_UPPER_E = 8'h45;
  localparam logic [7:0] CH_LOWER_E = 8'h65;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;

  // int64 maximum divided by ten
  localparam logic [62:0] LIMIT_BY_TEN = 63'd922337203685477580;
  localparam logic [15:0] LEN_MAX      = 16'hFFFF;

  localparam logic [1:0] DIALECT_TRANSITION = 2'd2;
  localparam logic [1:0] DIALECT_RESET      = 2'd3;

  typedef enum logic [2:0] {
    KIND_INT32  = 3'd0,
    KIND_INT64  = 3'd1,
    KIND_SCALED = 3'd2,
    KIND_FLOAT  = 3'd3,
    KIND_NAN    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    TAKE_OK  = 2'd0,
    TAKE_END = 2'd1,
    TAKE_ERR = 2'd2
  } take_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
    logic       at_end;
  } in_beat_t;

  typedef struct packed {
    kind_e       kind;
    logic [62:0] value;
    logic [15:0] length;
    logic        warn;
  } res_t;

  typedef struct packed {
    logic        scanning;
    logic        seen_digit;
    logic        seen_point;
    logic        seen_exp;
    logic        seen_exp_sign;
    logic        seen_exp_digit;
    logic        too_big;
    logic [62:0] acc;
    logic [15:0] count;
  } scan_t;

endpackage

`default_nettype wire

/* rtl/snlc_in_reg.sv */
// ----------------------------------------------------------------------------
// snlc_in_reg
// Input register: captures one character beat and holds it until consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module snlc_in_reg
  import snlc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t beat_i,
  input  wire logic     drain_i,
  output logic          valid_o,
  output in_beat_t      beat_o
);

  logic     valid_q, valid_d;
  in_beat_t beat_q;
  logic     load;

  assign in_stall_o = valid_q && !drain_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

/* rtl/snlc_scan.sv */
// ----------------------------------------------------------------------------
// snlc_scan
// Literal scanner: per-byte flag and accumulator update plus classification.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module snlc_scan
  import snlc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire in_beat_t   beat_i,
  input  wire logic [1:0] dialect_i,
  output logic            emit_o,
  output res_t            res_o
);

  scan_t       state_q, state_d;
  scan_t       take_st, fresh;
  take_e       tr;
  logic        dig, is_point, is_sign, is_e, can_start;
  logic        err, err_eff;
  logic [62:0] acc_x10;
  logic [62:0] digit_val;
  kind_e       kind;
  logic        warn;

  always_comb begin
    dig       = beat_i.ch inside {[CH_ZERO:CH_NINE]};
    is_point  = beat_i.ch == CH_POINT;
    is_sign   = (beat_i.ch == CH_MINUS) || (beat_i.ch == CH_PLUS);
    is_e      = (beat_i.ch == CH_UPPER_E) || (beat_i.ch == CH_LOWER_E);
    can_start = beat_i.start_req && (dig || is_point);
    digit_val = {59'd0, beat_i.ch[3:0]};
    acc_x10   = {state_q.acc[59:0], 3'b000} + {state_q.acc[61:0], 1'b0};
  end

  // Take one byte into an open literal.
  always_comb begin
    take_st = state_q;
    tr      = TAKE_OK;
    if (state_q.seen_exp_digit && !dig) begin
      tr = TAKE_END;
    end else if (state_q.seen_exp_sign && !dig) begin
      tr = TAKE_ERR;
    end else if (state_q.seen_exp) begin
      if (is_sign) begin
        take_st.seen_exp_sign = 1'b1;
      end else if (dig) begin
        take_st.seen_exp_sign  = 1'b1;
        take_st.seen_exp_digit = 1'b1;
      end else begin
        tr = TAKE_ERR;
      end
    end else if (is_point) begin
      if (state_q.seen_point) begin
        tr = TAKE_ERR;
      end else begin
        take_st.seen_point = 1'b1;
      end
    end else if (dig) begin
      take_st.seen_digit = 1'b1;
      if (state_q.acc >= LIMIT_BY_TEN) begin
        take_st.too_big = 1'b1;
      end else begin
        take_st.acc = acc_x10 + digit_val;
      end
    end else if (is_e && state_q.seen_digit) begin
      take_st.seen_exp = 1'b1;
    end else begin
      tr = TAKE_END;
    end
    if ((tr == TAKE_OK) && (state_q.count != LEN_MAX)) begin
      take_st.count = state_q.count + 16'd1;
    end
  end

  // State after a starting byte on a cleared literal.
  always_comb begin
    fresh            = '0;
    fresh.scanning   = 1'b1;
    fresh.seen_digit = dig;
    fresh.seen_point = !dig;
    fresh.acc        = dig ? digit_val : '0;
    fresh.count      = 16'd1;
  end

  always_comb begin
    state_d = state_q;
    emit_o  = 1'b0;
    err     = 1'b0;
    if (step_i) begin
      if (beat_i.at_end) begin
        if (state_q.scanning) begin
          emit_o           = 1'b1;
          state_d.scanning = 1'b0;
        end
      end else if (!state_q.scanning) begin
        if (can_start) begin
          state_d = fresh;
        end
      end else if (tr == TAKE_OK) begin
        state_d = take_st;
      end else begin
        emit_o           = 1'b1;
        err              = tr == TAKE_ERR;
        state_d.scanning = 1'b0;
        if (can_start) begin
          state_d = fresh;
        end
      end
    end
  end

  // Classify the literal held in state_q.
  always_comb begin
    err_eff = err || !state_q.seen_digit ||
              (state_q.too_big && !(state_q.seen_exp || state_q.seen_point));
    kind = KIND_NAN;
    warn = 1'b0;
    if (!err_eff) begin
      if (state_q.seen_exp_digit || state_q.too_big) begin
        kind = KIND_FLOAT;
      end else if (!state_q.seen_exp) begin
        if (!state_q.seen_point && (state_q.acc[62:31] == '0)) begin
          kind = KIND_INT32;
        end else begin
          warn = dialect_i == DIALECT_TRANSITION;
          if (dialect_i < DIALECT_TRANSITION) begin
            kind = KIND_FLOAT;
          end else if (state_q.seen_point) begin
            kind = KIND_SCALED;
          end else begin
            kind = KIND_INT64;
          end
        end
      end
    end
    res_o.kind   = kind;
    res_o.value  = ((kind == KIND_INT32) || (kind == KIND_INT64) || (kind == KIND_SCALED))
                   ? state_q.acc : '0;
    res_o.length = state_q.count;
    res_o.warn   = warn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  `SNLC_ASSERT_IMPL(a_sign_needs_exp, state_q.seen_exp_sign, state_q.seen_exp, "exp sign without exp mark")
  `SNLC_ASSERT_IMPL(a_expdig_needs_sign, state_q.seen_exp_digit, state_q.seen_exp_sign, "exp digit without sign flag")
  `SNLC_ASSERT_IMPL(a_open_has_length, state_q.scanning, state_q.count != 16'd0, "open literal with zero length")

endmodule

`default_nettype wire

/* rtl/snlc_out_reg.sv */
// ----------------------------------------------------------------------------
// snlc_out_reg
// Result register: holds one classified literal until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module snlc_out_reg
  import snlc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire res_t res_i,
  input  wire logic out_stall_i,
  output logic      free_o,
  output logic      out_valid_o,
  output res_t      res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // Slot is free when empty or when its beat leaves this cycle.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q && out_stall_i;
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* rtl/sql_numeric_literal_classifier.sv */
// A byte accepted into the input register updates the scanner when it steps; a
// result it closes is loaded into the result register on that same step.
// Throughput: one byte per cycle, sustained, while the result slot drains.
// The combinational scanner step (one 63-bit times-ten add and limit compare)
// sets the rate. Reset (rst_ni low, async) empties both registers, closes
// any open literal and sets the dialect register to 3.
// ----------------------------------------------------------------------------
// sql_numeric_literal_classifier
// Streams text bytes, scans SQL numeric literals and emits one classified
// result (kind, value, length, ambiguity warning) per finished literal.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sql_numeric_literal_classifier
  import snlc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // character beats
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        start_req_i,
  input  wire logic        at_end_i,
  // dialect register
  input  wire logic        sql_dialect_we_i,
  input  wire logic [1:0]  sql_dialect_i,
  // result beats
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic [62:0]      value_o,
  output logic [15:0]      length_o,
  output logic             warn_ambiguous_o
);

  logic [1:0] sql_dialect_q;
  in_beat_t   in_beat, beat_q;
  logic       beat_valid;
  logic       out_free;
  logic       step;
  logic       emit;
  res_t       res, res_q;

  // Dialect register; the user must write it only while the block is idle, the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sql_dialect_q <= DIALECT_RESET;
    end else if (sql_dialect_we_i) begin
      sql_dialect_q <= sql_dialect_i;
    end
  end

  assign in_beat.ch        = ch_i;
  assign in_beat.start_req = start_req_i;
  assign in_beat.at_end    = at_end_i;

  // Input register: refill in the same cycle the held beat advances.
  snlc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .drain_i    (out_free),
    .valid_o    (beat_valid),
    .beat_o     (beat_q)
  );

  // Advance the held beat only when a result it may close has a free slot.
  assign step = beat_valid && out_free;

  snlc_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .beat_i    (beat_q),
    .dialect_i (sql_dialect_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  snlc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (res_q)
  );

  assign kind_o           = res_q.kind;
  assign value_o          = res_q.value;
  assign length_o         = res_q.length;
  assign warn_ambiguous_o = res_q.warn;

  `SNLC_ASSERT_IMPL(a_emit_into_free_slot, emit, out_free, "result written over a waiting beat")
  `SNLC_ASSERT_IMPL(a_float_nan_zero_value, out_valid_o && (kind_o == KIND_FLOAT || kind_o == KIND_NAN), value_o == '0, "nonzero value on float or nan")
  `SNLC_ASSERT_IMPL(a_warn_only_transition, out_valid_o && warn_ambiguous_o, sql_dialect_q == DIALECT_TRANSITION, "warning outside transition dialect")

endmodule

`default_nettype wire

/* tb/sql_numeric_literal_classifier_tb.sv */
// ----------------------------------------------------------------------------
// sql_numeric_literal_classifier_tb
// Streams text beats into the numeric literal classifier and checks every
// result beat against an in-bench scanner that classifies the same text.
// ----------------------------------------------------------------------------
`default_nettype none

module sql_numeric_literal_classifier_tb;
  import snlc_pkg::*;

  // dialect codes without a package name
  localparam logic [1:0]  DIALECT_ZERO  = 2'd0;
  localparam logic [1:0]  DIALECT_FLOAT = 2'd1;
  localparam logic [62:0] INT32_TOP     = 63'd2147483647;
  localparam int          RESET_CYCLES  = 11;
  // drain padding so no-result bytes are absorbed
  localparam int          LATENCY_PAD   = 8;
  localparam int          STUCK_LIMIT   = 4000;
  localparam int          PHASE_COUNT   = 8;
  localparam int          HALF_PHASE    = 60;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [7:0]  ch            = 8'd0;
  logic        start_req     = 1'b0;
  logic        at_end        = 1'b0;
  logic        dialect_we    = 1'b0;
  logic [1:0]  dialect_wdata = DIALECT_RESET;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [2:0]  kind;
  logic [62:0] value;
  logic [15:0] length;
  logic        warn;

  sql_numeric_literal_classifier DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .ch_i               (ch),
    .start_req_i        (start_req),
    .at_end_i           (at_end),
    .sql_dialect_we_i   (dialect_we),
    .sql_dialect_i      (dialect_wdata),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .kind_o             (kind),
    .value_o            (value),
    .length_o           (length),
    .warn_ambiguous_o   (warn)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Text waiting to be driven, and classified literals waiting to come out.
  in_beat_t text_q[$];
  res_t     results_due[$];

  int  gap_pct    = 0;     // chance per cycle that the sender holds off
  int  stall_pct  = 0;     // chance per cycle that the receiver stalls
  bit  beat_taken = 1'b0;  // input beat accepted at the last rising edge
  int  mismatches = 0;
  int  stuck_cycles = 0;

  // --------------------------------------------------------------------------
  // Scanner copy: the literal currently open in the text stream
  // --------------------------------------------------------------------------
  logic [1:0]  txt_dialect = DIALECT_RESET;
  logic        lit_open, lit_digit, lit_point, lit_exp;
  logic        lit_exp_sign, lit_exp_digit, lit_big;
  logic [62:0] lit_acc;
  logic [15:0] lit_len;

  initial begin
    lit_open = 1'b0; lit_digit = 1'b0; lit_point = 1'b0; lit_exp = 1'b0;
    lit_exp_sign = 1'b0; lit_exp_digit = 1'b0; lit_big = 1'b0;
    lit_acc = '0; lit_len = '0;
  end

  function automatic bit is_dec(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Close the open literal and queue its classification.
  function automatic void close_literal(bit err);
    res_t r;
    bit   bad;
    bad    = err || !lit_digit || (lit_big && !(lit_exp || lit_point));
    r.kind = KIND_NAN;
    r.warn = 1'b0;
    if (!bad) begin
      if (lit_exp_digit || lit_big) begin
        r.kind = KIND_FLOAT;
      end else if (!lit_exp) begin
        if (!lit_point && lit_acc <= INT32_TOP) begin
          r.kind = KIND_INT32;
        end else begin
          // wide or fractional: the dialect decides
          if (txt_dialect == DIALECT_TRANSITION) r.warn = 1'b1;
          if (txt_dialect < DIALECT_TRANSITION) r.kind = KIND_FLOAT;
          else if (lit_point) r.kind = KIND_SCALED;
          else r.kind = KIND_INT64;
        end
      end
    end
    if (r.kind == KIND_INT32 || r.kind == KIND_INT64 || r.kind == KIND_SCALED) begin
      r.value = lit_acc;
    end else begin
      r.value = '0;
    end
    r.length = lit_len;
    results_due.push_back(r);
    lit_open = 1'b0;
  endfunction

  // Fold one byte into the open literal, or say how it ends it.
  function automatic take_e absorb(logic [7:0] c);
    bit dig;
    dig = is_dec(c);
    if (lit_exp_digit && !dig) return TAKE_END;
    if (lit_exp_sign && !dig) return TAKE_ERR;
    if (lit_exp) begin
      if (c == CH_MINUS || c == CH_PLUS) begin
        lit_exp_sign = 1'b1;
      end else if (dig) begin
        // exponent digits only move flags, never the value
        lit_exp_digit = 1'b1;
        lit_exp_sign  = 1'b1;
      end else begin
        return TAKE_ERR;
      end
    end else if (c == CH_POINT) begin
      if (lit_point) return TAKE_ERR;
      lit_point = 1'b1;
    end else if (dig) begin
      lit_digit = 1'b1;
      if (lit_acc >= LIMIT_BY_TEN) lit_big = 1'b1;
      else lit_acc = lit_acc * 63'd10 + 63'(c - CH_ZERO);
    end else if ((c == CH_UPPER_E || c == CH_LOWER_E) && lit_digit) begin
      lit_exp = 1'b1;
    end else begin
      return TAKE_END;
    end
    if (lit_len != LEN_MAX) lit_len = lit_len + 16'd1;
    return TAKE_OK;
  endfunction

  function automatic void open_literal(logic [7:0] c);
    lit_open = 1'b1;
    lit_digit = 1'b0; lit_point = 1'b0; lit_exp = 1'b0;
    lit_exp_sign = 1'b0; lit_exp_digit = 1'b0; lit_big = 1'b0;
    lit_acc = '0;
    lit_len = '0;
    void'(absorb(c));
  endfunction

  // Work out what one accepted text beat produces.
  function automatic void classify_beat(logic [7:0] c, logic s, logic f);
    bit    can_open;
    take_e t;
    can_open = s && (is_dec(c) || c == CH_POINT);
    if (f) begin
      if (lit_open) close_literal(1'b0);
      return;
    end
    if (!lit_open) begin
      // a start on a byte that cannot begin a literal is dropped here
      if (can_open) open_literal(c);
      return;
    end
    t = absorb(c);
    if (t == TAKE_OK) return;
    close_literal(t == TAKE_ERR);
    // the terminating byte may open the next literal
    if (can_open) open_literal(c);
  endfunction

  function automatic void check_field(string what, logic [62:0] got, logic [62:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: advance to the next text beat once the current one is taken,
  // hold the payload while stalled, and randomize the receiver stall.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    in_beat_t nb;
    out_stall <= ($urandom_range(99) < stall_pct);
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (text_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nb = text_q.pop_front();
        in_valid  <= 1'b1;
        ch        <= nb.ch;
        start_req <= nb.start_req;
        at_end    <= nb.at_end;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check result beats, classify accepted text beats, and watch
  // for a stuck handshake.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      beat_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d value %0d length %0d",
                   $time, kind, value, length);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", 63'(kind), 63'(want.kind));
          check_field("value", value, want.value);
          check_field("length", 63'(length), 63'(want.length));
          check_field("warn_ambiguous", 63'(warn), 63'(want.warn));
        end
      end
      if (in_valid && !in_stall) classify_beat(ch, start_req, at_end);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
        $display("sql_numeric_literal_classifier regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_beat(input logic [7:0] c, input logic s, input logic f);
    in_beat_t b;
    b.ch        = c;
    b.start_req = s;
    b.at_end    = f;
    text_q.push_back(b);
  endtask

  // Literal byte: start on the first one, a stray start now and then after.
  task automatic lit_byte(input logic [7:0] c, inout bit first);
    push_beat(c, first || ($urandom_range(9) == 0), 1'b0);
    first = 1'b0;
  endtask

  // Hold until the sender is empty and every result is back, then pad.
  task automatic drain(input int pad);
    while (text_q.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk_i);
    repeat (pad) @(posedge clk_i);
  endtask

  task automatic write_dialect(input logic [1:0] d);
    @(negedge clk_i);
    dialect_we    <= 1'b1;
    dialect_wdata <= d;
    txt_dialect    = d;
    @(negedge clk_i);
    dialect_we    <= 1'b0;
  endtask

  // One literal with random content, mostly well formed; returns bytes queued.
  task automatic queue_literal(output int n_bytes);
    string       near_edges[6];
    logic [7:0]  digs[$];
    logic [7:0]  c;
    int          form, n_dig, pt_at, flaw, q_mark;
    bit          first, has_exp;
    near_edges = '{"2147483647", "2147483648", "922337203685477579",
                   "9223372036854775799", "922337203685477580", "0"};
    q_mark = text_q.size();
    first  = 1'b1;
    form   = $urandom_range(9);
    if (form < 5) n_dig = $urandom_range(8, 1);
    else if (form < 7) n_dig = $urandom_range(12, 9);
    else if (form < 8) n_dig = $urandom_range(22, 17);
    else n_dig = $urandom_range(2, 0);
    if (form >= 8) begin
      // values at the int32 and int64 edges, up to two digits appended
      string s;
      s = near_edges[$urandom_range(5)];
      for (int i = 0; i < s.len(); i++) digs.push_back(s[i]);
    end
    for (int i = 0; i < n_dig; i++) digs.push_back(8'($urandom_range(CH_NINE, CH_ZERO)));
    pt_at   = ($urandom_range(9) < 4) ? $urandom_range(digs.size()) : -1;
    has_exp = ($urandom_range(9) < 3);
    flaw    = ($urandom_range(9) < 2) ? $urandom_range(4) : -1;
    if (flaw == 3) begin
      // point with no digit at all
      digs.delete();
      pt_at = 0;
    end
    for (int i = 0; i <= digs.size(); i++) begin
      if (i == pt_at) lit_byte(CH_POINT, first);
      if (i < digs.size()) lit_byte(digs[i], first);
    end
    case (flaw)
      0: begin
        lit_byte(CH_POINT, first);
        lit_byte(CH_POINT, first);
      end
      1: begin
        lit_byte(CH_LOWER_E, first);
        do c = 8'($urandom_range(255));
        while (is_dec(c) || c == CH_PLUS || c == CH_MINUS);
        lit_byte(c, first);
      end
      2: begin
        lit_byte(CH_UPPER_E, first);
        lit_byte($urandom_range(1) ? CH_PLUS : CH_MINUS, first);
        do c = 8'($urandom_range(255));
        while (is_dec(c));
        lit_byte(c, first);
      end
      default: begin
        if (has_exp) begin
          lit_byte($urandom_range(1) ? CH_UPPER_E : CH_LOWER_E, first);
          if ($urandom_range(1)) lit_byte($urandom_range(1) ? CH_PLUS : CH_MINUS, first);
          repeat ($urandom_range(3, 1)) lit_byte(8'($urandom_range(CH_NINE, CH_ZERO)), first);
        end
      end
    endcase
    // terminator; after exponent digits the next literal may close this one
    if (!(has_exp && flaw < 0 && $urandom_range(4) == 0)) begin
      case ($urandom_range(3))
        0, 1: begin
          string seps;
          seps = " ,;)+-*/";
          push_beat(seps[$urandom_range(seps.len() - 1)], 1'($urandom_range(1)), 1'b0);
        end
        2: push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        default: push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0);
      endcase
    end
    n_bytes = text_q.size() - q_mark;
  endtask

  task automatic queue_text(input int target);
    int got, n, k;
    got = 0;
    while (got < target) begin
      if ($urandom_range(99) < 85) begin
        queue_literal(n);
        got += n;
      end else begin
        // noise: any byte, any flags
        k = $urandom_range(4, 1);
        repeat (k) begin
          push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), $urandom_range(7) == 0);
        end
        got += k;
      end
    end
  endtask

  task automatic queue_directed();
    push_beat("a", 1'b1, 1'b0);        // start on a byte that cannot begin
    push_beat(8'hFF, 1'b0, 1'b1);      // end of text with nothing open
    // exponent digit, then a point that ends it and opens ".5"
    push_beat("9", 1'b1, 1'b0);
    push_beat("e", 1'b0, 1'b0);
    push_beat("+", 1'b0, 1'b0);
    push_beat("7", 1'b0, 1'b0);
    push_beat(".", 1'b1, 1'b0);
    push_beat("5", 1'b0, 1'b0);
    push_beat(8'h00, 1'b0, 1'b0);
    // second point errors out and opens a digitless literal
    push_beat("1", 1'b1, 1'b0);
    push_beat(".", 1'b0, 1'b0);
    push_beat(".", 1'b1, 1'b0);
    push_beat(8'h00, 1'b1, 1'b1);
    // bad byte after the exponent mark
    push_beat("1", 1'b1, 1'b0);
    push_beat("E", 1'b0, 1'b0);
    push_beat("x", 1'b0, 1'b0);
    // bad byte after the exponent sign
    push_beat("1", 1'b1, 1'b0);
    push_beat("e", 1'b0, 1'b0);
    push_beat("-", 1'b0, 1'b0);
    push_beat(":", 1'b0, 1'b0);
    push_beat(" ", 1'b0, 1'b0);
  endtask

  initial begin
    logic [1:0] dialect_plan[PHASE_COUNT];
    dialect_plan = '{DIALECT_RESET, DIALECT_FLOAT, DIALECT_TRANSITION, DIALECT_ZERO,
                     DIALECT_RESET, DIALECT_TRANSITION, DIALECT_FLOAT, DIALECT_RESET};
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // phase 0 runs on the reset dialect
      if (p != 0) write_dialect(dialect_plan[p]);
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      if (p == 0) begin
        queue_directed();
      end
      queue_text(HALF_PHASE);
      // sender holds off until every result so far has drained
      drain(0);
      queue_text(HALF_PHASE);
      // close whatever is open so the dialect changes on an idle block
      push_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
      drain(LATENCY_PAD);
    end

    if (results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("sql_numeric_literal_classifier regression: pass");
    end else begin
      $display("sql_numeric_literal_classifier regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sql_numeric_literal_classifier.f */
+incdir+rtl
rtl/snlc_pkg.sv
rtl/snlc_in_reg.sv
rtl/snlc_scan.sv
rtl/snlc_out_reg.sv
rtl/sql_numeric_literal_classifier.sv
tb/sql_numeric_literal_classifier_tb.sv
